FILE: design/lmsab_pkg.sv
package lmsab_pkg;

  // default geometry and converter width
  localparam int unsigned ROWS_DEF        = 16;
  localparam int unsigned COLUMNS_DEF     = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned ROW_W_DEF       = $clog2(ROWS_DEF);
  localparam int unsigned COL_W_DEF       = $clog2(COLUMNS_DEF);

  // fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned TIME_W    = 10;
  localparam int unsigned SE_W      = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 10;

  // light history and on time formula
  localparam int unsigned HIST_DEPTH = 5;
  localparam int unsigned ON_SCALE   = 10;
  localparam int unsigned ON_OFFSET  = 81;
  localparam int unsigned ON_DIVISOR = 18;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHOW      = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_EVERY  = 3'd4;

  // register reset values
  localparam logic [TIME_W-1:0] FRAME_PERIOD_RST  = 10'd500;
  localparam logic [TIME_W-1:0] BRIGHT_LIMIT_RST  = 10'd900;
  localparam logic [TIME_W-1:0] DARK_LIMIT_RST    = 10'd11;
  localparam logic [TIME_W-1:0] OVERLAP_LIMIT_RST = 10'd450;
  localparam logic [SE_W-1:0]   SAMPLE_EVERY_RST  = 6'd20;

endpackage

FILE: design/lmsab_if.sv
interface lmsab_in_if #(
  parameter int unsigned ROW_W       = lmsab_pkg::ROW_W_DEF,
  parameter int unsigned COL_W       = lmsab_pkg::COL_W_DEF,
  parameter int unsigned SAMPLE_BITS = lmsab_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic                   pixel_on;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row_sel;
  logic                   color;
  logic [SAMPLE_BITS-1:0] light_sample;

  modport source (
    output valid, cmd, pixel_on, col, row_sel, color, light_sample,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_on, col, row_sel, color, light_sample,
    output ready
  );
endinterface

interface lmsab_out_if #(
  parameter int unsigned ROW_W   = lmsab_pkg::ROW_W_DEF,
  parameter int unsigned COLUMNS = lmsab_pkg::COLUMNS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_index;
  logic [COLUMNS-1:0] green_word;
  logic [COLUMNS-1:0] red_word;
  logic [9:0]         on_time;
  logic [9:0]         off_time;
  logic               keep_enabled;
  logic               last_row;

  modport source (
    output valid, row_index, green_word, red_word, on_time, off_time, keep_enabled,
           last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, green_word, red_word, on_time, off_time, keep_enabled,
           last_row,
    output ready
  );
endinterface

FILE: design/led_matrix_scan_auto_brightness_unit.sv
// channel   dir  beat contents
// in_i      in   cmd, pixel_on, col, row_sel, color, light_sample
// out_o     out  row_index, green_word, red_word, on_time, off_time, keep_enabled, last_row
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// set pixel: read of the row word, then write back through the frame ram.
// clear frame: it drops the per-row valid bits, so no sweep of the ram.
// show: brightness arithmetic (sum, divide by 5, scale, divide by 18),
// then ROWS beats at one a cycle, each stalled for as long as out_o.ready is low.
// reset: frame store reads all dark straight away, history and counter zero.
module led_matrix_scan_auto_brightness_unit #(
  parameter int unsigned ROWS        = lmsab_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS     = lmsab_pkg::COLUMNS_DEF,
  parameter int unsigned SAMPLE_BITS = lmsab_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmsab_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmsab_pkg::CFG_W-1:0]     cfg_data_i,
  lmsab_in_if.sink                        in_i,
  lmsab_out_if.source                     out_o
);
  import lmsab_pkg::*;

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CNT_W  = ROW_W + 1;
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(HIST_DEPTH);
  localparam int unsigned CMP_W  = (SAMPLE_BITS > TIME_W) ? SAMPLE_BITS : TIME_W;
  localparam int unsigned X_W    = SAMPLE_BITS + $clog2(ON_SCALE);
  // reciprocal multipliers, exact for every value of the dividend width
  localparam int unsigned K5     = SUM_W + $clog2(HIST_DEPTH);
  localparam int unsigned M5_W   = K5 - $clog2(HIST_DEPTH) + 1;
  localparam longint unsigned M5_VAL =
    ((longint'(1) << K5) + HIST_DEPTH - 1) / HIST_DEPTH;
  localparam logic [M5_W-1:0] M5 = M5_W'(M5_VAL);
  localparam int unsigned K18    = X_W + $clog2(ON_DIVISOR);
  localparam int unsigned M18_W  = K18 - $clog2(ON_DIVISOR) + 1;
  localparam longint unsigned M18_VAL =
    ((longint'(1) << K18) + ON_DIVISOR - 1) / ON_DIVISOR;
  localparam logic [M18_W-1:0] M18 = M18_W'(M18_VAL);
  localparam int unsigned Q18_W  = X_W - $clog2(ON_DIVISOR) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WR   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_AVG  = 3'd3;
  localparam logic [2:0] ST_X    = 3'd4;
  localparam logic [2:0] ST_ON   = 3'd5;
  localparam logic [2:0] ST_SCAN = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [TIME_W-1:0]      frame_period_q, bright_limit_q, dark_limit_q, overlap_limit_q;
  logic [SE_W-1:0]        sample_every_q;
  logic [SE_W-1:0]        cnt_q, cnt_d, period;
  logic [SE_W:0]          cnt_inc;
  logic [SAMPLE_BITS-1:0] hist_q [HIST_DEPTH];
  logic [ROWS-1:0]        g_vld_q, r_vld_q;

  logic                   in_beat, set_ok, rd_set, issue, load, last_load;
  logic [CNT_W-1:0]       rd_row_q;
  logic                   pend_q;
  logic [ROW_W-1:0]       pend_row_q;
  logic                   pend_gv_q, pend_rv_q;

  logic [ROW_W-1:0]       wr_row_q;
  logic [COL_W-1:0]       wr_bit_q;
  logic                   wr_plane_q, wr_on_q;
  logic [COLUMNS-1:0]     wr_base, wr_mask, wr_word;

  logic [ROW_W-1:0]       raddr;
  logic [COLUMNS-1:0]     g_rdata, r_rdata;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W+M5_W-1:0]  prod5;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [X_W-1:0]         ten_avg, x_q;
  logic                   bright_q, dark_q, neg_q;
  logic [X_W+M18_W-1:0]   prod18;
  logic [TIME_W-1:0]      on_d, on_q;

  logic                   out_vld_q;
  logic [ROW_W-1:0]       out_row_q;
  logic [COLUMNS-1:0]     out_g_q, out_r_q;
  logic [TIME_W-1:0]      out_on_q, out_off_q;
  logic                   out_keep_q, out_last_q;

  // handshake decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign set_ok     = ({1'b0, in_i.row_sel} < CNT_W'(ROWS)) &&
                      ({1'b0, in_i.col} < (COL_W + 1)'(COLUMNS));
  assign rd_set     = in_beat && (in_i.cmd == CMD_SET_PIXEL) && set_ok;

  // scan pipeline: read issue, ram data stage, output register
  assign load      = pend_q && (!out_vld_q || out_o.ready);
  assign issue     = (state_q == ST_SCAN) && (rd_row_q < CNT_W'(ROWS)) && (!pend_q || load);
  assign last_load = load && (pend_row_q == ROW_W'(ROWS - 1));
  assign raddr     = (state_q == ST_IDLE) ? in_i.row_sel : rd_row_q[ROW_W-1:0];

  // read-modify-write of one row word
  assign wr_base = wr_plane_q ? (r_vld_q[wr_row_q] ? r_rdata : '1)
                              : (g_vld_q[wr_row_q] ? g_rdata : '1);
  assign wr_mask = {{(COLUMNS-1){1'b0}}, 1'b1} << wr_bit_q;
  assign wr_word = wr_on_q ? (wr_base & ~wr_mask) : (wr_base | wr_mask);

  lmsab_ram #(.WIDTH(COLUMNS), .DEPTH(ROWS)) u_green_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_WR) && !wr_plane_q),
    .waddr_i (wr_row_q),
    .wdata_i (wr_word),
    .re_i    (rd_set || issue),
    .raddr_i (raddr),
    .rdata_o (g_rdata)
  );

  lmsab_ram #(.WIDTH(COLUMNS), .DEPTH(ROWS)) u_red_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_WR) && wr_plane_q),
    .waddr_i (wr_row_q),
    .wdata_i (wr_word),
    .re_i    (rd_set || issue),
    .raddr_i (raddr),
    .rdata_o (r_rdata)
  );

  // sample counter wrap
  assign period  = (sample_every_q == '0) ? SE_W'(1) : sample_every_q;
  assign cnt_inc = {1'b0, cnt_q} + (SE_W + 1)'(1);
  assign cnt_d   = (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[SE_W-1:0];

  // brightness arithmetic
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      sum_d = sum_d + SUM_W'(hist_q[k]);
    end
  end

  assign prod5   = sum_q * M5;
  assign ten_avg = (X_W'(avg_q) << 3) + (X_W'(avg_q) << 1);
  assign prod18  = x_q * M18;

  always_comb begin
    if (bright_q) begin
      on_d = frame_period_q;
    end else if (dark_q) begin
      on_d = TIME_W'(1);
    end else if (neg_q) begin
      on_d = '0;
    end else begin
      on_d = TIME_W'(prod18[K18 +: Q18_W]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rd_set) begin
          state_d = ST_WR;
        end else if (in_beat && (in_i.cmd == CMD_SHOW)) begin
          state_d = ST_SUM;
        end
      end
      ST_WR:   state_d = ST_IDLE;
      ST_SUM:  state_d = ST_AVG;
      ST_AVG:  state_d = ST_X;
      ST_X:    state_d = ST_ON;
      ST_ON:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (last_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, configuration, history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      frame_period_q  <= FRAME_PERIOD_RST;
      bright_limit_q  <= BRIGHT_LIMIT_RST;
      dark_limit_q    <= DARK_LIMIT_RST;
      overlap_limit_q <= OVERLAP_LIMIT_RST;
      sample_every_q  <= SAMPLE_EVERY_RST;
      cnt_q           <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
      g_vld_q         <= '0;
      r_vld_q         <= '0;
      rd_row_q        <= '0;
      pend_q          <= 1'b0;
      out_vld_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_PERIOD:  frame_period_q  <= cfg_data_i[TIME_W-1:0];
          REG_BRIGHT_LIMIT:  bright_limit_q  <= cfg_data_i[TIME_W-1:0];
          REG_DARK_LIMIT:    dark_limit_q    <= cfg_data_i[TIME_W-1:0];
          REG_OVERLAP_LIMIT: overlap_limit_q <= cfg_data_i[TIME_W-1:0];
          REG_SAMPLE_EVERY:  sample_every_q  <= cfg_data_i[SE_W-1:0];
          default: ;
        endcase
      end

      if (in_beat && (in_i.cmd == CMD_SHOW)) begin
        cnt_q <= cnt_d;
        if (cnt_q == '0) begin
          for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            hist_q[k] <= hist_q[k-1];
          end
          hist_q[0] <= in_i.light_sample;
        end
      end

      // valid bits: clear frame drops all, a write-back marks its row
      if (in_beat && (in_i.cmd == CMD_CLEAR)) begin
        g_vld_q <= '0;
        r_vld_q <= '0;
      end else if (state_q == ST_WR) begin
        if (wr_plane_q) begin
          r_vld_q[wr_row_q] <= 1'b1;
        end else begin
          g_vld_q[wr_row_q] <= 1'b1;
        end
      end

      if (state_q == ST_ON) begin
        rd_row_q <= '0;
      end else if (issue) begin
        rd_row_q <= rd_row_q + CNT_W'(1);
      end

      if (issue) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end

      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_set) begin
      wr_row_q   <= in_i.row_sel;
      wr_bit_q   <= COL_W'(COLUMNS - 1) - in_i.col;
      wr_plane_q <= in_i.color;
      wr_on_q    <= in_i.pixel_on;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_AVG) begin
      avg_q <= prod5[K5 +: SAMPLE_BITS];
    end
    if (state_q == ST_X) begin
      bright_q <= CMP_W'(avg_q) > CMP_W'(bright_limit_q);
      dark_q   <= CMP_W'(avg_q) < CMP_W'(dark_limit_q);
      neg_q    <= ten_avg < X_W'(ON_OFFSET);
      x_q      <= ten_avg - X_W'(ON_OFFSET);
    end
    if (state_q == ST_ON) begin
      on_q <= on_d;
    end
    if (issue) begin
      pend_row_q <= rd_row_q[ROW_W-1:0];
      pend_gv_q  <= g_vld_q[rd_row_q[ROW_W-1:0]];
      pend_rv_q  <= r_vld_q[rd_row_q[ROW_W-1:0]];
    end
    if (load) begin
      out_row_q  <= pend_row_q;
      out_g_q    <= pend_gv_q ? g_rdata : '1;
      out_r_q    <= pend_rv_q ? r_rdata : '1;
      out_on_q   <= on_q;
      out_off_q  <= (frame_period_q > on_q) ? (frame_period_q - on_q) : '0;
      out_keep_q <= on_q > overlap_limit_q;
      out_last_q <= pend_row_q == ROW_W'(ROWS - 1);
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.row_index    = out_row_q;
  assign out_o.green_word   = out_g_q;
  assign out_o.red_word     = out_r_q;
  assign out_o.on_time      = out_on_q;
  assign out_o.off_time     = out_off_q;
  assign out_o.keep_enabled = out_keep_q;
  assign out_o.last_row     = out_last_q;

`ifndef NO_ASSERTIONS
  // no ram data left behind once the block takes new items
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_q)
    else $error("row data pending while input is open");

  // a row other than the last one on the output means the scan is still running
  a_scan_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_row) |-> (state_q == ST_SCAN))
    else $error("scan left before last row");

  // write-back always follows the read issued on the set pixel beat
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> ($past(state_q) == ST_IDLE))
    else $error("write-back without preceding read");
`endif

endmodule

FILE: design/lmsab_ram.sv
module lmsab_ram #(
  parameter int unsigned WIDTH = lmsab_pkg::COLUMNS_DEF,
  parameter int unsigned DEPTH = lmsab_pkg::ROWS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  import lmsab_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port that holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
